@@ rtl/mct_pkg.sv @@
// Package for the mouse cursor tracker: beat types, event codes and reset constants.
`timescale 1ns / 1ps
`default_nettype none

package mct_pkg;

   // Event codes carried in the cmd field of a request beat.
   typedef enum logic [1:0] {
      CMD_MOUSE  = 2'd0,
      CMD_FRAME  = 2'd1,
      CMD_REPORT = 2'd2,
      CMD_SECOND = 2'd3
   } cmd_type;

   // Control frame type bytes.
   localparam logic [7:0] FRAME_CONNECT = 8'd0;
   localparam logic [7:0] FRAME_CANCEL  = 8'd2;

   // Frame lengths that matter.
   localparam logic [8:0] FRAME_MIN_LEN     = 9'd3;
   localparam logic [8:0] FRAME_CONNECT_LEN = 9'd10;

   // Only complete three-byte mouse packets are decoded.
   localparam logic [3:0] MOUSE_PACKET_LEN = 4'd3;

   // Reset values of the session state, and the ceiling of the elapsed count.
   localparam logic [15:0] LIMIT_X_RESET = 16'd255;
   localparam logic [15:0] LIMIT_Y_RESET = 16'd191;
   localparam logic [7:0]  TIMEOUT_RESET = 8'd30;
   localparam logic [8:0]  ELAPSED_MAX   = 9'd511;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  mouse_len;
      logic [7:0]  status_byte;
      logic [7:0]  dx_byte;
      logic [7:0]  dy_byte;
      logic [8:0]  frame_len;
      logic [7:0]  frame_type;
      logic [15:0] frame_width;
      logic [15:0] frame_height;
      logic [7:0]  frame_timeout;
   } req_type;

   typedef struct packed {
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [2:0]  button_bits;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/mouse_cursor_tracker_with_reporting_core.sv @@
// Top level of the mouse cursor tracker with session-gated position reporting.
`timescale 1ns / 1ps
`default_nettype none

//  Channel | Direction | Handshake            | Beat
//  --------+-----------+----------------------+-----------------------------------
//  req_    | in        | req_valid, req_stall | mct_pkg::req_type (one event)
//  rsp_    | out       | rsp_valid, rsp_stall | mct_pkg::rsp_type (cursor report)
//
// An event is caught in the input register at the edge that accepts it. From
// there the decode, clamp and session logic update the state and, when a
// report is made, load the result register, where the report is offered. A
// new beat can be taken in every cycle unless the input register stalls.
// Reset is synchronous and clears the session state to its power-up values.
// The input register stalls only when it holds a report tick that would emit
// while the result register is still full and held by rsp_stall.

module mouse_cursor_tracker_with_reporting_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mct_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mct_pkg::rsp_type      rsp_data
);

   import mct_pkg::*;

   // Input register.
   logic    in_valid_ff;
   req_type in_data_ff;

   // Session and cursor state.
   logic [15:0] cursor_x_ff, cursor_x_in;
   logic [15:0] cursor_y_ff, cursor_y_in;
   logic [2:0]  buttons_ff, buttons_in;
   logic        pending_ff, pending_in;
   logic        locked_ff, locked_in;
   logic [15:0] limit_x_ff, limit_x_in;
   logic [15:0] limit_y_ff, limit_y_in;
   logic [7:0]  timeout_ff, timeout_in;
   logic [8:0]  elapsed_ff, elapsed_in;

   // Result register.
   logic    out_valid_ff;
   rsp_type out_data_ff;

   // Decode of the mouse packet held in the input register.
   logic               packet_ok;
   logic signed [17:0] delta_x;
   logic signed [17:0] delta_y;
   logic signed [17:0] sum_x;
   logic signed [17:0] sum_y;
   logic [15:0]        clamp_x;
   logic [15:0]        clamp_y;

   logic emit;
   logic advance;

   always_comb begin
      packet_ok = (in_data_ff.mouse_len == MOUSE_PACKET_LEN)
                  && in_data_ff.status_byte[3]
                  && (in_data_ff.status_byte[7:6] == 2'b00);
      // Nine-bit signed deltas; the Y axis of the mouse points the other way.
      delta_x = {{10{in_data_ff.status_byte[4]}}, in_data_ff.dx_byte};
      delta_y = -{{10{in_data_ff.status_byte[5]}}, in_data_ff.dy_byte};
      sum_x   = $signed({2'b00, cursor_x_ff}) + delta_x;
      sum_y   = $signed({2'b00, cursor_y_ff}) + delta_y;
      // The floor at zero is tested first; as a limit is never negative, this
      // gives the same cursor as clamping to the limit and then to zero.
      if (sum_x < 18'sd0) begin
         clamp_x = 16'd0;
      end else if (sum_x > $signed({2'b00, limit_x_ff})) begin
         clamp_x = limit_x_ff;
      end else begin
         clamp_x = sum_x[15:0];
      end
      if (sum_y < 18'sd0) begin
         clamp_y = 16'd0;
      end else if (sum_y > $signed({2'b00, limit_y_ff})) begin
         clamp_y = limit_y_ff;
      end else begin
         clamp_y = sum_y[15:0];
      end
   end

   // A report is emitted only on a report tick while the session is locked
   // and something has changed since the last report.
   assign emit = in_valid_ff && (in_data_ff.cmd == CMD_REPORT) && locked_ff && pending_ff;

   // The held event takes effect unless it must emit into a full, stalled
   // result register.
   assign advance   = in_valid_ff && !(emit && out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      buttons_in  = buttons_ff;
      pending_in  = pending_ff;
      locked_in   = locked_ff;
      limit_x_in  = limit_x_ff;
      limit_y_in  = limit_y_ff;
      timeout_in  = timeout_ff;
      elapsed_in  = elapsed_ff;
      if (advance) begin
         case (in_data_ff.cmd)
            CMD_MOUSE: begin
               if (packet_ok && ((clamp_x != cursor_x_ff) || (clamp_y != cursor_y_ff)
                                 || (in_data_ff.status_byte[2:0] != buttons_ff))) begin
                  cursor_x_in = clamp_x;
                  cursor_y_in = clamp_y;
                  buttons_in  = in_data_ff.status_byte[2:0];
                  pending_in  = 1'b1;
               end
            end
            CMD_FRAME: begin
               if (in_data_ff.frame_len >= FRAME_MIN_LEN) begin
                  if ((in_data_ff.frame_type == FRAME_CONNECT)
                      && (in_data_ff.frame_len == FRAME_CONNECT_LEN)) begin
                     locked_in  = 1'b1;
                     pending_in = 1'b1;
                     limit_x_in = (in_data_ff.frame_width == 16'd0) ? 16'd0
                                  : in_data_ff.frame_width - 16'd1;
                     limit_y_in = (in_data_ff.frame_height == 16'd0) ? 16'd0
                                  : in_data_ff.frame_height - 16'd1;
                     timeout_in = in_data_ff.frame_timeout;
                  end
                  if (in_data_ff.frame_type == FRAME_CANCEL) begin
                     locked_in = 1'b0;
                  end
                  // Any frame of usable length refreshes the session age.
                  elapsed_in = 9'd0;
               end
            end
            CMD_REPORT: begin
               if (locked_ff) begin
                  // A stale session ends here, yet a pending report still goes
                  // out on this tick.
                  if (elapsed_ff > {1'b0, timeout_ff}) begin
                     locked_in = 1'b0;
                  end
                  if (pending_ff) begin
                     pending_in = 1'b0;
                  end
               end
            end
            CMD_SECOND: begin
               if (elapsed_ff < ELAPSED_MAX) begin
                  elapsed_in = elapsed_ff + 9'd1;
               end
            end
            default: begin
               elapsed_in = elapsed_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cursor_x_ff  <= 16'd0;
         cursor_y_ff  <= 16'd0;
         buttons_ff   <= 3'd0;
         pending_ff   <= 1'b0;
         locked_ff    <= 1'b0;
         limit_x_ff   <= LIMIT_X_RESET;
         limit_y_ff   <= LIMIT_Y_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         elapsed_ff   <= 9'd0;
      end else begin
         // The input register takes a new beat whenever it is free or moving on.
         if (!req_stall) begin
            in_valid_ff <= req_valid;
            if (req_valid) begin
               in_data_ff <= req_data;
            end
         end
         // The result register empties when taken and loads when a report is made.
         if (advance && emit) begin
            out_valid_ff      <= 1'b1;
            out_data_ff.pos_x <= cursor_x_ff;
            out_data_ff.pos_y <= cursor_y_ff;
            out_data_ff.button_bits <= buttons_ff;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         buttons_ff  <= buttons_in;
         pending_ff  <= pending_in;
         locked_ff   <= locked_in;
         limit_x_ff  <= limit_x_in;
         limit_y_ff  <= limit_y_in;
         timeout_ff  <= timeout_in;
         elapsed_ff  <= elapsed_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire
